@@ sv/gbvc_pkg.sv @@
package gbvc_pkg;

	// Data path widths
	localparam int unsigned CW       = 28;  // CORDIC x/y, 8 extra fraction bits
	localparam int unsigned ZW       = 34;  // CORDIC angle, 2^32 per turn
	localparam int unsigned MW       = 34;  // shared multiplier operand width
	localparam int unsigned PW       = 2 * MW;
	localparam int unsigned MAX_ITER = 24;
	localparam int unsigned IW       = $clog2(MAX_ITER + 1);
	localparam int unsigned DEF_ROTATION_ITERATIONS = 16;

	localparam logic signed [MW-1:0] GAIN_Q16 = 34'sd39797;
	localparam logic signed [MW-1:0] PI_Q29   = 34'sd1686629713;
	localparam logic signed [ZW-1:0] ANG_PI   = 34'sd2147483648;
	localparam logic signed [ZW-1:0] ANG_HPI  = 34'sd1073741824;

	// Register indexes
	typedef enum logic [2:0] {
		REG_DEADBAND  = 3'd0,
		REG_FWD_LIM   = 3'd1,
		REG_LAT_LIM   = 3'd2,
		REG_HDG_GAIN  = 3'd3,
		REG_TURN_LIM  = 3'd4,
		REG_FWD_ACC   = 3'd5,
		REG_LAT_ACC   = 3'd6,
		REG_TURN_ACC  = 3'd7
	} reg_idx_t;

	typedef enum logic [4:0] {
		S_IDLE, S_SQX, S_SQY, S_SQD, S_DBCMP, S_ROT, S_GX, S_GY,
		S_VINIT, S_VEC, S_ERR, S_YAW, S_YCLP, S_SF, S_SL, S_ST, S_OUT
	} state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic vector;
	} cordic_ctrl_t;

	// Arctangent of 2^-i in units of 2^32 per turn
	function automatic logic signed [ZW-1:0] atan_at(input logic [IW-1:0] i);
		logic signed [ZW-1:0] a;
		case (i)
			5'd0:  a = 34'sd536870912;
			5'd1:  a = 34'sd316933406;
			5'd2:  a = 34'sd167458907;
			5'd3:  a = 34'sd85004756;
			5'd4:  a = 34'sd42667331;
			5'd5:  a = 34'sd21354465;
			5'd6:  a = 34'sd10679838;
			5'd7:  a = 34'sd5340245;
			5'd8:  a = 34'sd2670163;
			5'd9:  a = 34'sd1335087;
			5'd10: a = 34'sd667544;
			5'd11: a = 34'sd333772;
			5'd12: a = 34'sd166886;
			5'd13: a = 34'sd83443;
			5'd14: a = 34'sd41722;
			5'd15: a = 34'sd20861;
			5'd16: a = 34'sd10430;
			5'd17: a = 34'sd5215;
			5'd18: a = 34'sd2608;
			5'd19: a = 34'sd1304;
			5'd20: a = 34'sd652;
			5'd21: a = 34'sd326;
			5'd22: a = 34'sd163;
			5'd23: a = 34'sd81;
			default: a = '0;
		endcase
		return a;
	endfunction

	// Symmetric clamp to +/- lim
	function automatic logic signed [15:0] clamp_sym(input logic signed [35:0] v,
			input logic [14:0] lim);
		logic signed [35:0] l;
		logic signed [15:0] r;
		l = signed'({21'b0, lim});
		if (v > l)
			r = 16'(l);
		else if (v < -l)
			r = 16'(-l);
		else
			r = v[15:0];
		return r;
	endfunction

	// Move from prev toward desired by at most step; bypass returns desired
	function automatic logic signed [15:0] slew(input logic signed [15:0] desired,
			input logic signed [15:0] prev, input logic [15:0] step, input logic bypass);
		logic signed [16:0] d;
		logic signed [16:0] s;
		logic signed [16:0] r;
		d = 17'(desired) - 17'(prev);
		s = signed'({1'b0, step});
		if (d > s)
			d = s;
		else if (d < -s)
			d = -s;
		r = 17'(prev) + d;
		return bypass ? desired : r[15:0];
	endfunction

endpackage

@@ sv/gbvc_cordic.sv @@
module gbvc_cordic import gbvc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cordic_ctrl_t         ctrl,
	input  logic [IW-1:0]        iter,
	input  logic signed [CW-1:0] x0,
	input  logic signed [CW-1:0] y0,
	input  logic signed [ZW-1:0] z0,
	output logic signed [CW-1:0] x,
	output logic signed [CW-1:0] y,
	output logic signed [ZW-1:0] z
);

	logic signed [CW-1:0] x_q, y_q, xs, ys;
	logic signed [ZW-1:0] z_q, a;
	logic                 ccw;

	// One micro-rotation per cycle while ctrl.step is set
	always_comb begin
		xs  = x_q >>> iter;
		ys  = y_q >>> iter;
		a   = atan_at(iter);
		ccw = ctrl.vector ? !(y_q > 0) : (z_q >= 0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= '0;
			y_q <= '0;
			z_q <= '0;
		end else if (ctrl.load) begin
			x_q <= x0;
			y_q <= y0;
			z_q <= z0;
		end else if (ctrl.step) begin
			if (ccw) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - a;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + a;
			end
		end
	end

	assign x = x_q;
	assign y = y_q;
	assign z = z_q;

	a_iter_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.step |-> iter < 5'(MAX_ITER)) else $error("cordic iteration out of range");
	a_no_both: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctrl.load && ctrl.step)) else $error("cordic load and step together");
	a_load_takes: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.load |=> z_q == $past(z0)) else $error("cordic load lost");

endmodule

@@ sv/guidance_to_body_velocity_command_unit.sv @@
// Turns a world-frame guidance velocity, yaw and step time into a slew-limited
// body-frame velocity and yaw-rate command. One word is taken at a time: in_stall
// stays high from acceptance until the result word has been taken. A word inside
// the deadband goes from the deadband check to the result; any other runs two CORDIC
// passes (rotation, then vectoring) of min(ROTATION_ITERATIONS, 24) iterations on
// one shared micro-rotation unit plus ten products on one shared multiplier.
// Configuration writes apply to the next word only if made while idle; not enforced.
module guidance_to_body_velocity_command_unit import gbvc_pkg::*; #(
	parameter int unsigned ROTATION_ITERATIONS = DEF_ROTATION_ITERATIONS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] guide_x,
	input  logic signed [15:0] guide_y,
	input  logic signed [15:0] heading,
	input  logic [15:0]        step_time,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] cmd_forward,
	output logic signed [15:0] cmd_lateral,
	output logic signed [15:0] cmd_turn_rate,
	output logic               in_deadband
);

	localparam int unsigned ITERS =
		(ROTATION_ITERATIONS > MAX_ITER) ? MAX_ITER : ROTATION_ITERATIONS;
	localparam logic [IW-1:0] LAST_ITER = IW'(ITERS - 1);

	state_t state_q, state_d;

	logic [14:0] deadband_q, fwd_lim_q, lat_lim_q, turn_lim_q;
	logic [15:0] hdg_gain_q, fwd_acc_q, lat_acc_q, turn_acc_q;

	logic signed [15:0] gx_q, gy_q, hd_q;
	logic [15:0]        dt_q;
	logic [IW-1:0]      iter_q;
	logic [MW-1:0]      acc_q;
	logic signed [PW-1:0] prod_q;
	logic signed [MW-1:0] mul_a, mul_b;
	logic signed [15:0] bx_q, by_q, yr_q;
	logic signed [15:0] prev_fwd_q, prev_lat_q, prev_turn_q;
	logic               have_prev_q;
	logic signed [15:0] cmd_fwd_q, cmd_lat_q, cmd_turn_q;
	logic               in_db_q;

	cordic_ctrl_t         cctl;
	logic signed [CW-1:0] cx0, cy0, cx, cy;
	logic signed [ZW-1:0] cz0, cz;

	logic signed [PW-1:0] gain_rnd, yaw_rnd;
	logic signed [ZW-1:0] hd_ang, z_rot, err_diff, err_e;
	logic [31:0]          err_u;
	logic                 slew_off;
	logic signed [15:0]   pf, pl, pt;

	// Shared CORDIC unit
	gbvc_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (cctl),
		.iter   (iter_q),
		.x0     (cx0),
		.y0     (cy0),
		.z0     (cz0),
		.x      (cx),
		.y      (cy),
		.z      (cz)
	);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadband_q <= 15'd205;
			fwd_lim_q  <= 15'd4096;
			lat_lim_q  <= 15'd2048;
			hdg_gain_q <= 16'd4096;
			turn_lim_q <= 15'd4096;
			fwd_acc_q  <= 16'd8192;
			lat_acc_q  <= 16'd8192;
			turn_acc_q <= 16'd8192;
		end else if (cfg_write) begin
			case (reg_idx_t'(cfg_index))
				REG_DEADBAND: deadband_q <= cfg_data[14:0];
				REG_FWD_LIM:  fwd_lim_q  <= cfg_data[14:0];
				REG_LAT_LIM:  lat_lim_q  <= cfg_data[14:0];
				REG_HDG_GAIN: hdg_gain_q <= cfg_data;
				REG_TURN_LIM: turn_lim_q <= cfg_data[14:0];
				REG_FWD_ACC:  fwd_acc_q  <= cfg_data;
				REG_LAT_ACC:  lat_acc_q  <= cfg_data;
				REG_TURN_ACC: turn_acc_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Angle helpers, rounding, slew bypass and previous-command select
	always_comb begin
		hd_ang   = ZW'(hd_q) <<< 16;
		z_rot    = -hd_ang;
		err_diff = cz - hd_ang;
		err_u    = err_diff[31:0];
		err_e    = (err_u > 32'h8000_0000) ? (ZW'({2'b0, err_u}) - (ANG_PI <<< 1))
			: ZW'({2'b0, err_u});
		gain_rnd = prod_q + (PW'(1) <<< 23);
		yaw_rnd  = prod_q + (PW'(1) <<< 43);
		slew_off = (dt_q == 16'd0);
		pf = have_prev_q ? prev_fwd_q : 16'sd0;
		pl = have_prev_q ? prev_lat_q : 16'sd0;
		pt = have_prev_q ? prev_turn_q : 16'sd0;
	end

	// Sequencer: next state, multiplier operands, CORDIC control
	always_comb begin
		state_d = state_q;
		mul_a   = '0;
		mul_b   = '0;
		cctl    = '0;
		cx0     = CW'(gx_q) <<< 8;
		cy0     = CW'(gy_q) <<< 8;
		cz0     = z_rot;
		case (state_q)
			S_IDLE: if (in_valid) state_d = S_SQX;
			S_SQX: begin
				mul_a = MW'(gx_q);
				mul_b = MW'(gx_q);
				state_d = S_SQY;
			end
			S_SQY: begin
				mul_a = MW'(gy_q);
				mul_b = MW'(gy_q);
				state_d = S_SQD;
			end
			S_SQD: begin
				mul_a = signed'(MW'(deadband_q));
				mul_b = signed'(MW'(deadband_q));
				state_d = S_DBCMP;
			end
			S_DBCMP: begin
				if (acc_q <= prod_q[MW-1:0]) begin
					state_d = S_OUT;
				end else begin
					cctl.load = 1'b1;
					if (z_rot > ANG_HPI) begin
						cx0 = -cx0;
						cy0 = -cy0;
						cz0 = z_rot - ANG_PI;
					end else if (z_rot < -ANG_HPI) begin
						cx0 = -cx0;
						cy0 = -cy0;
						cz0 = z_rot + ANG_PI;
					end
					state_d = S_ROT;
				end
			end
			S_ROT: begin
				cctl.step = 1'b1;
				if (iter_q == LAST_ITER) state_d = S_GX;
			end
			S_GX: begin
				mul_a = MW'(cx);
				mul_b = GAIN_Q16;
				state_d = S_GY;
			end
			S_GY: begin
				mul_a = MW'(cy);
				mul_b = GAIN_Q16;
				state_d = S_VINIT;
			end
			S_VINIT: begin
				cctl.load   = 1'b1;
				cctl.vector = 1'b1;
				cz0 = '0;
				if (gx_q < 0) begin
					cx0 = -cx0;
					cy0 = -cy0;
					cz0 = ANG_PI;
				end
				state_d = S_VEC;
			end
			S_VEC: begin
				cctl.step   = 1'b1;
				cctl.vector = 1'b1;
				if (iter_q == LAST_ITER) state_d = S_ERR;
			end
			S_ERR: begin
				mul_a = signed'(MW'(hdg_gain_q));
				mul_b = err_e;
				state_d = S_YAW;
			end
			S_YAW: begin
				mul_a = prod_q[MW+15:16];
				mul_b = PI_Q29;
				state_d = S_YCLP;
			end
			S_YCLP: begin
				mul_a = signed'(MW'(fwd_acc_q));
				mul_b = signed'(MW'(dt_q));
				state_d = S_SF;
			end
			S_SF: begin
				mul_a = signed'(MW'(lat_acc_q));
				mul_b = signed'(MW'(dt_q));
				state_d = S_SL;
			end
			S_SL: begin
				mul_a = signed'(MW'(turn_acc_q));
				mul_b = signed'(MW'(dt_q));
				state_d = S_ST;
			end
			S_ST: state_d = S_OUT;
			S_OUT: if (!out_stall) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// State and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			iter_q      <= '0;
			have_prev_q <= 1'b0;
			prev_fwd_q  <= '0;
			prev_lat_q  <= '0;
			prev_turn_q <= '0;
		end else begin
			state_q <= state_d;
			if (cctl.step)
				iter_q <= (iter_q == LAST_ITER) ? '0 : iter_q + IW'(1);
			case (state_q)
				S_DBCMP: if (acc_q <= prod_q[MW-1:0]) begin
					have_prev_q <= 1'b0;
					prev_fwd_q  <= '0;
					prev_lat_q  <= '0;
					prev_turn_q <= '0;
				end
				S_SF: prev_fwd_q <= slew(bx_q, pf, prod_q[31:16], slew_off || fwd_acc_q == 16'd0);
				S_SL: prev_lat_q <= slew(by_q, pl, prod_q[31:16], slew_off || lat_acc_q == 16'd0);
				S_ST: begin
					prev_turn_q <= slew(yr_q, pt, prod_q[31:16],
						slew_off || turn_acc_q == 16'd0);
					have_prev_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// Data path registers
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		case (state_q)
			S_IDLE: begin
				gx_q <= guide_x;
				gy_q <= guide_y;
				hd_q <= heading;
				dt_q <= step_time;
			end
			S_SQY: acc_q <= prod_q[MW-1:0];
			S_SQD: acc_q <= acc_q + prod_q[MW-1:0];
			S_DBCMP: begin
				in_db_q    <= (acc_q <= prod_q[MW-1:0]);
				cmd_fwd_q  <= '0;
				cmd_lat_q  <= '0;
				cmd_turn_q <= '0;
			end
			S_GY:    bx_q <= clamp_sym(gain_rnd[59:24], fwd_lim_q);
			S_VINIT: by_q <= clamp_sym(gain_rnd[59:24], lat_lim_q);
			S_YCLP:  yr_q <= clamp_sym(36'(signed'(yaw_rnd[PW-1:44])), turn_lim_q);
			S_SF: cmd_fwd_q <= slew(bx_q, pf, prod_q[31:16], slew_off || fwd_acc_q == 16'd0);
			S_SL: cmd_lat_q <= slew(by_q, pl, prod_q[31:16], slew_off || lat_acc_q == 16'd0);
			S_ST: cmd_turn_q <= slew(yr_q, pt, prod_q[31:16],
				slew_off || turn_acc_q == 16'd0);
			default: ;
		endcase
	end

	assign in_stall      = (state_q != S_IDLE);
	assign out_valid     = (state_q == S_OUT);
	assign cmd_forward   = cmd_fwd_q;
	assign cmd_lateral   = cmd_lat_q;
	assign cmd_turn_rate = cmd_turn_q;
	assign in_deadband   = in_db_q;

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> state_q == S_SQX) else $error("accepted word not started");
	a_db_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && in_deadband |-> cmd_forward == 0 && cmd_lateral == 0 &&
		cmd_turn_rate == 0 && !have_prev_q) else $error("deadband result not cleared");
	a_prev_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !in_deadband |-> prev_fwd_q == cmd_forward &&
		prev_turn_q == cmd_turn_rate && have_prev_q) else $error("stored command mismatch");
	a_iter_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> iter_q == '0) else $error("iteration counter not rewound");

endmodule

@@ tb/sv/guidance_to_body_velocity_command_unit_tb.sv @@
`timescale 1ns / 100ps

module guidance_to_body_velocity_command_unit_tb import gbvc_pkg::*; ();

	typedef struct {
		logic signed [15:0] gx;
		logic signed [15:0] gy;
		logic signed [15:0] hd;
		logic [15:0]        dt;
	} guide_word_t;

	typedef struct {
		logic signed [15:0] fwd;
		logic signed [15:0] lat;
		logic signed [15:0] turn;
		logic               db;
	} cmd_word_t;

	localparam int NITER = DEF_ROTATION_ITERATIONS;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_write = 1'b0;
	logic [2:0]         cfg_index = '0;
	logic [15:0]        cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic signed [15:0] guide_x = '0;
	logic signed [15:0] guide_y = '0;
	logic signed [15:0] heading = '0;
	logic [15:0]        step_time = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [15:0] cmd_forward;
	logic signed [15:0] cmd_lateral;
	logic signed [15:0] cmd_turn_rate;
	logic               in_deadband;

	guide_word_t pending_words[$];
	cmd_word_t   expected_cmds[$];
	int          errors = 0;
	int          send_gap = 0;
	int          take_gap = 0;
	bit          hold_send = 1'b0;

	// predictor copy of registers and stored command
	logic [15:0]        regs_m[8];
	logic signed [15:0] last_fwd, last_lat, last_turn;

	guidance_to_body_velocity_command_unit dut (.*);

	always #5 clk = ~clk;

	function automatic longint fshr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint clamp_to(longint v, longint lim);
		if (v > lim)
			return lim;
		if (v < -lim)
			return -lim;
		return v;
	endfunction

	function automatic longint atan_of(int i);
		longint tab[24] = '{536870912, 316933406, 167458907, 85004756, 42667331,
			21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
			83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};
		return tab[i];
	endfunction

	function automatic logic signed [15:0] slew_to(longint want, longint prev,
			longint acc, longint dt);
		longint stp;
		if (dt == 0 || acc == 0)
			return 16'(want);
		stp = (acc * dt) >>> 16;
		return 16'(prev + clamp_to(want - prev, stp));
	endfunction

	// compute the command word for one guidance word and advance the stored command
	function automatic cmd_word_t body_command(guide_word_t w);
		cmd_word_t r;
		longint gx, gy, hd, x, y, z, nx, bx, by, e, t, yr, dbs;
		longint unsigned eu;
		int n;
		gx = w.gx;
		gy = w.gy;
		hd = w.hd;
		n = (NITER > 24) ? 24 : NITER;
		dbs = regs_m[REG_DEADBAND];
		if (gx * gx + gy * gy <= dbs * dbs) begin
			last_fwd = 0;
			last_lat = 0;
			last_turn = 0;
			r = '{0, 0, 0, 1'b1};
			return r;
		end
		x = gx * 256;
		y = gy * 256;
		z = -hd * 65536;
		if (z > 64'sd1073741824) begin
			x = -x; y = -y; z -= 64'sd2147483648;
		end else if (z < -64'sd1073741824) begin
			x = -x; y = -y; z += 64'sd2147483648;
		end
		for (int i = 0; i < n; i++) begin
			if (z >= 0) begin
				nx = x - fshr(y, i); y = y + fshr(x, i); z -= atan_of(i);
			end else begin
				nx = x + fshr(y, i); y = y - fshr(x, i); z += atan_of(i);
			end
			x = nx;
		end
		bx = clamp_to(fshr(x * 39797 + (64'sd1 << 23), 24), regs_m[REG_FWD_LIM]);
		by = clamp_to(fshr(y * 39797 + (64'sd1 << 23), 24), regs_m[REG_LAT_LIM]);
		x = gx * 256;
		y = gy * 256;
		z = 0;
		if (x < 0) begin
			x = -x; y = -y; z = 64'sd2147483648;
		end
		for (int i = 0; i < n; i++) begin
			if (y > 0) begin
				nx = x + fshr(y, i); y = y - fshr(x, i); z += atan_of(i);
			end else begin
				nx = x - fshr(y, i); y = y + fshr(x, i); z -= atan_of(i);
			end
			x = nx;
		end
		eu = longint'(z - hd * 65536) & 64'hFFFF_FFFF;
		e = (eu > 64'd2147483648) ? longint'(eu) - 64'sd4294967296 : longint'(eu);
		t = fshr(longint'(regs_m[REG_HDG_GAIN]) * e, 16);
		yr = fshr(t * 64'sd1686629713 + (64'sd1 << 43), 44);
		yr = clamp_to(yr, regs_m[REG_TURN_LIM]);
		// stored command is already zero whenever the deadband cleared it
		r.fwd = slew_to(bx, last_fwd, regs_m[REG_FWD_ACC], w.dt);
		r.lat = slew_to(by, last_lat, regs_m[REG_LAT_ACC], w.dt);
		r.turn = slew_to(yr, last_turn, regs_m[REG_TURN_ACC], w.dt);
		r.db = 1'b0;
		last_fwd = r.fwd;
		last_lat = r.lat;
		last_turn = r.turn;
		return r;
	endfunction

	function automatic int pick_gap();
		int p;
		p = $urandom_range(0, 99);
		if (p < 40)
			return 0;
		if (p < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// drive guidance words; advance only on acceptance
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				expected_cmds.push_back(body_command('{guide_x, guide_y, heading,
					step_time}));
				send_gap <= pick_gap();
			end
			if (!in_valid || !in_stall) begin
				if (!(in_valid && !in_stall) && send_gap > 0)
					send_gap <= send_gap - 1;
				if (pending_words.size() > 0 && !hold_send &&
						(send_gap == 0 || (in_valid && !in_stall && 0))) begin
					if (in_valid && !in_stall) begin
						in_valid <= 1'b0;
					end else begin
						guide_word_t w;
						w = pending_words.pop_front();
						in_valid <= 1'b1;
						guide_x <= w.gx;
						guide_y <= w.gy;
						heading <= w.hd;
						step_time <= w.dt;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// check command words and pace the receiver
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				cmd_word_t exp_w;
				if (expected_cmds.size() == 0) begin
					$error("unexpected command word");
					errors++;
				end else begin
					exp_w = expected_cmds.pop_front();
					if (cmd_forward !== exp_w.fwd) begin
						$error("cmd_forward exp %0d got %0d", exp_w.fwd, cmd_forward);
						errors++;
					end
					if (cmd_lateral !== exp_w.lat) begin
						$error("cmd_lateral exp %0d got %0d", exp_w.lat, cmd_lateral);
						errors++;
					end
					if (cmd_turn_rate !== exp_w.turn) begin
						$error("cmd_turn_rate exp %0d got %0d", exp_w.turn, cmd_turn_rate);
						errors++;
					end
					if (in_deadband !== exp_w.db) begin
						$error("in_deadband exp %0d got %0d", exp_w.db, in_deadband);
						errors++;
					end
				end
			end
			if (take_gap > 0) begin
				take_gap <= take_gap - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
				if ($urandom_range(0, 3) == 0)
					take_gap <= pick_gap();
			end
		end
	end

	task automatic wait_drained();
		while (pending_words.size() > 0 || in_valid || expected_cmds.size() > 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, int val);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= 16'(val);
		@(posedge clk);
		cfg_write <= 1'b0;
		if (idx == REG_HDG_GAIN || idx >= REG_FWD_ACC)
			regs_m[idx] = 16'(val);
		else
			regs_m[idx] = 16'(val) & 16'h7FFF;
	endtask

	function automatic guide_word_t rand_word(int mode);
		guide_word_t w;
		w.hd = 16'($urandom);
		w.dt = ($urandom_range(0, 9) == 0) ? 16'(0) : 16'($urandom_range(0, 65535)
			>> $urandom_range(0, 12));
		case (mode)
			0: begin
				w.gx = 16'($urandom); w.gy = 16'($urandom);
			end
			1: begin
				w.gx = $signed(16'($urandom_range(0, 8191))) - 16'sd4096;
				w.gy = $signed(16'($urandom_range(0, 8191))) - 16'sd4096;
			end
			default: begin
				w.gx = $signed(16'($urandom_range(0, 600))) - 16'sd300;
				w.gy = $signed(16'($urandom_range(0, 600))) - 16'sd300;
			end
		endcase
		return w;
	endfunction

	task automatic load_random(int count);
		repeat (count) pending_words.push_back(rand_word($urandom_range(0, 3) % 3));
	endtask

	initial begin
		logic [15:0] resets[8] = '{205, 4096, 2048, 4096, 4096, 8192, 8192, 8192};
		foreach (regs_m[i]) regs_m[i] = resets[i];
		last_fwd = 0;
		last_lat = 0;
		last_turn = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		// directed: extremes, zero guidance, deadband edges, bypass of slew
		pending_words.push_back('{0, 0, 0, 100});
		pending_words.push_back('{205, 0, 0, 1000});
		pending_words.push_back('{206, 0, 0, 1000});
		pending_words.push_back('{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'hFFFF});
		pending_words.push_back('{-16'sh8000, -16'sh8000, -16'sh8000, 16'hFFFF});
		pending_words.push_back('{-16'sh8000, 0, 16'sh4000, 0});
		pending_words.push_back('{0, 16'sh7FFF, -16'sh4000, 1});
		pending_words.push_back('{4096, 0, -16'sh8000, 16'h8000});
		pending_words.push_back('{-4096, 10, 16'sh2000, 3});
		pending_words.push_back('{4096, 4096, 16'sh6000, 0});
		pending_words.push_back('{16'sh5555, -16'sh2AAB, 16'sh5555, 16'hAAAA});
		pending_words.push_back('{0, 0, 16'sh1234, 0});
		load_random(300);
		// hold off sending until all commands have come back
		repeat (2000) @(posedge clk);
		hold_send = 1'b1;
		while (in_valid || expected_cmds.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		hold_send = 1'b0;
		wait_drained();
		write_reg(REG_DEADBAND, 0);
		write_reg(REG_FWD_LIM, 16'h7FFF);
		write_reg(REG_LAT_LIM, 16'h7FFF);
		write_reg(REG_HDG_GAIN, 16'hFFFF);
		write_reg(REG_TURN_LIM, 16'h7FFF);
		write_reg(REG_FWD_ACC, 0);
		write_reg(REG_LAT_ACC, 16'hFFFF);
		write_reg(REG_TURN_ACC, 0);
		pending_words.push_back('{0, 0, 0, 5});
		pending_words.push_back('{1, 0, 0, 5});
		load_random(500);
		wait_drained();
		write_reg(REG_DEADBAND, 16'h7FFF);
		write_reg(REG_FWD_LIM, 0);
		write_reg(REG_LAT_LIM, 0);
		write_reg(REG_HDG_GAIN, 0);
		write_reg(REG_TURN_LIM, 0);
		write_reg(REG_FWD_ACC, 1);
		write_reg(REG_LAT_ACC, 0);
		write_reg(REG_TURN_ACC, 16'hFFFF);
		load_random(200);
		wait_drained();
		write_reg(REG_DEADBAND, $urandom_range(0, 1000));
		write_reg(REG_FWD_LIM, $urandom_range(1000, 20000));
		write_reg(REG_LAT_LIM, $urandom_range(1000, 20000));
		write_reg(REG_HDG_GAIN, $urandom_range(1000, 40000));
		write_reg(REG_TURN_LIM, $urandom_range(1000, 20000));
		write_reg(REG_FWD_ACC, $urandom_range(1, 30000));
		write_reg(REG_LAT_ACC, $urandom_range(1, 30000));
		write_reg(REG_TURN_ACC, $urandom_range(1, 30000));
		load_random(840);
		wait_drained();
		if (errors == 0)
			$display("guidance_to_body_velocity_command_unit test passed");
		else
			$display("guidance_to_body_velocity_command_unit test failed");
		$finish;
	end

	// run limit: every word at full latency plus the longest stalls on both sides
	initial begin
		#20ms;
		$display("guidance_to_body_velocity_command_unit test failed");
		$finish;
	end

endmodule

@@ files.f @@
sv/gbvc_pkg.sv
sv/gbvc_cordic.sv
sv/guidance_to_body_velocity_command_unit.sv
tb/sv/guidance_to_body_velocity_command_unit_tb.sv
